// ----- sv/ipe_pkg.sv -----
// ipe_pkg: shared constants, command struct and calendar table for the
// timestamp parser. No dependencies.
`timescale 1ns / 1ps

package ipe_pkg;

  localparam logic [4:0] MIN_TEXT_LEN = 5'd19;
  localparam logic [4:0] FRACTION_LEN = 5'd23;
  localparam logic [4:0] POS_SATURATE = 5'd24;

  localparam logic [4:0] POS_DASH_A   = 5'd4;
  localparam logic [4:0] POS_DASH_B   = 5'd7;
  localparam logic [4:0] POS_TEE      = 5'd10;
  localparam logic [4:0] POS_COLON_A  = 5'd13;
  localparam logic [4:0] POS_COLON_B  = 5'd16;
  localparam logic [4:0] POS_DOT      = 5'd19;
  localparam logic [4:0] POS_FRAC_A   = 5'd20;
  localparam logic [4:0] POS_FRAC_B   = 5'd21;
  localparam logic [4:0] POS_FRAC_C   = 5'd22;
  localparam logic [4:0] POS_YEAR_END = 5'd3;
  localparam logic [4:0] POS_MON_END  = 5'd6;
  localparam logic [4:0] POS_DAY_END  = 5'd9;
  localparam logic [4:0] POS_HOUR_END = 5'd12;
  localparam logic [4:0] POS_MIN_END  = 5'd15;

  localparam logic [9:0] MILLIS_BAD   = 10'd1023;
  localparam logic [9:0] MILLIS_MAX   = 10'd999;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_TEE   = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // reciprocal of 100 scaled by 2^19
  localparam logic [26:0] RECIP_100 = 27'd5243;
  // 365 * 1 + days from 0001-01-01 to 1970-01-01 plus the floor-division offsets
  localparam logic [24:0] DAY_BIAS  = 25'd719625;

  typedef struct packed {
    logic take;
    logic snap;
    logic calc;
    logic load;
  } ipe_cmd_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ipe_in_if.sv -----
// ipe_in_if: byte input channel with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps

interface ipe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source(output valid, output text_byte, output last_byte, input ready);
  modport sink(input valid, input text_byte, input last_byte, output ready);
endinterface

// ----- sv/ipe_out_if.sv -----
// ipe_out_if: result channel with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps

interface ipe_out_if;
  logic               valid;
  logic               ready;
  logic signed [48:0] epoch_millis;
  logic               well_formed;

  modport source(output valid, output epoch_millis, output well_formed, input ready);
  modport sink(input valid, input epoch_millis, input well_formed, output ready);
endinterface

// ----- sv/ipe_dp.sv -----
// ipe_dp: field accumulators, validation and epoch arithmetic.
// Depends on ipe_pkg; driven by commands from ipe_ctrl.
`timescale 1ns / 1ps

module ipe_dp
  import ipe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ipe_cmd_t           cmd,
  input  logic [7:0]         text_byte,
  output logic signed [48:0] epoch_millis,
  output logic               well_formed
);

  logic [4:0]  char_position;
  logic [13:0] year_acc;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic [6:0]  hour_acc;
  logic [6:0]  minute_acc;
  logic [6:0]  second_acc;
  logic [9:0]  millis_acc;
  logic        format_bad;
  logic        fraction_seen;

  logic        is_digit;
  logic [3:0]  digit;
  logic [4:0]  position_next;

  assign is_digit      = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign digit         = is_digit ? text_byte[3:0] : 4'd0;
  assign position_next = (char_position >= POS_SATURATE) ? POS_SATURATE
                                                         : char_position + 5'd1;

  // byte collection
  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      char_position <= '0;
      year_acc      <= '0;
      month_acc     <= '0;
      day_acc       <= '0;
      hour_acc      <= '0;
      minute_acc    <= '0;
      second_acc    <= '0;
      millis_acc    <= '0;
      format_bad    <= 1'b0;
      fraction_seen <= 1'b0;
    end else if (cmd.take) begin
      char_position <= position_next;
      if (char_position < FRACTION_LEN) begin
        case (char_position)
          POS_DASH_A, POS_DASH_B: begin
            if (text_byte != CH_DASH) format_bad <= 1'b1;
          end
          POS_TEE: begin
            if (text_byte != CH_TEE) format_bad <= 1'b1;
          end
          POS_COLON_A, POS_COLON_B: begin
            if (text_byte != CH_COLON) format_bad <= 1'b1;
          end
          POS_DOT: begin
            fraction_seen <= (text_byte == CH_DOT);
          end
          POS_FRAC_A, POS_FRAC_B, POS_FRAC_C: begin
            if (!is_digit) millis_acc <= MILLIS_BAD;
            else if (millis_acc != MILLIS_BAD)
              millis_acc <= 10'(millis_acc * 10'd10 + 10'(digit));
          end
          default: begin
            if (!is_digit) format_bad <= 1'b1;
            else if (char_position <= POS_YEAR_END)
              year_acc <= 14'(year_acc * 14'd10 + 14'(digit));
            else if (char_position <= POS_MON_END)
              month_acc <= 7'(month_acc * 7'd10 + 7'(digit));
            else if (char_position <= POS_DAY_END)
              day_acc <= 7'(day_acc * 7'd10 + 7'(digit));
            else if (char_position <= POS_HOUR_END)
              hour_acc <= 7'(hour_acc * 7'd10 + 7'(digit));
            else if (char_position <= POS_MIN_END)
              minute_acc <= 7'(minute_acc * 7'd10 + 7'(digit));
            else
              second_acc <= 7'(second_acc * 7'd10 + 7'(digit));
          end
        endcase
      end
    end
  end

  // snapshot stage: validation, century quotients, seconds of day
  logic [13:0] shifted;
  logic [26:0] prod_s100;
  logic [26:0] prod_s400;
  logic [26:0] prod_y100;
  logic [9:0]  ms_used;
  logic        ok_c;
  logic [16:0] secs_c;

  assign shifted   = year_acc + 14'd399;
  assign prod_s100 = 27'(shifted) * RECIP_100;
  assign prod_s400 = 27'(shifted[13:2]) * RECIP_100;
  assign prod_y100 = 27'(year_acc) * RECIP_100;
  assign ms_used   = (char_position >= FRACTION_LEN && fraction_seen) ? millis_acc : 10'd0;
  assign ok_c      = (char_position >= MIN_TEXT_LEN) && !format_bad
                     && (month_acc >= 7'd1) && (month_acc <= 7'd12)
                     && (day_acc >= 7'd1) && (day_acc <= 7'd31)
                     && (hour_acc <= 7'd23) && (minute_acc <= 7'd59)
                     && (second_acc <= 7'd59) && (ms_used <= MILLIS_MAX);
  assign secs_c    = 17'(17'(hour_acc) * 17'd3600 + 17'(minute_acc) * 17'd60
                         + 17'(second_acc));

  logic [13:0] s_year;
  logic [11:0] s_sh4;
  logic [6:0]  s_q100s;
  logic [4:0]  s_q400s;
  logic [6:0]  s_q100y;
  logic [3:0]  s_month;
  logic [4:0]  s_day;
  logic [16:0] s_secs;
  logic [9:0]  s_ms;
  logic        s_ok;

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      s_year  <= year_acc;
      s_sh4   <= shifted[13:2];
      s_q100s <= prod_s100[25:19];
      s_q400s <= prod_s400[23:19];
      s_q100y <= prod_y100[25:19];
      s_month <= month_acc[3:0];
      s_day   <= day_acc[4:0];
      s_secs  <= secs_c;
      s_ms    <= ms_used;
      s_ok    <= ok_c;
    end
  end

  // day count stage
  logic        leap;
  logic [24:0] day_sum;
  logic [26:0] tod_c;

  assign leap    = (s_year[1:0] == 2'd0)
                   && ((s_year != 14'(s_q100y * 14'd100)) || (s_q100y[1:0] == 2'd0))
                   && (s_month > 4'd2);
  assign day_sum = 25'(s_year) * 25'd365 + 25'(s_sh4) + 25'(s_q400s)
                   + 25'(month_start(s_month)) + 25'(leap) + 25'(s_day)
                   - 25'(s_q100s) - DAY_BIAS;
  assign tod_c   = 27'(s_secs) * 27'd1000 + 27'(s_ms);

  logic signed [24:0] c_days;
  logic [26:0]        c_tod;
  logic               c_ok;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      c_days <= $signed(day_sum);
      c_tod  <= tod_c;
      c_ok   <= s_ok;
    end
  end

  // final scale into milliseconds
  logic signed [52:0] total;

  assign total = 53'(c_days) * 53'sd86400000 + $signed(53'(c_tod));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      epoch_millis <= c_ok ? $signed(total[48:0]) : 49'sd0;
      well_formed  <= c_ok;
    end
  end

  snap_clears_position: assert property (@(posedge clk) disable iff (rst)
    cmd.snap |=> (char_position == 5'd0) && !format_bad)
    else $error("accumulators not cleared after snapshot");

endmodule

// ----- sv/ipe_ctrl.sv -----
// ipe_ctrl: sequencing of byte collection, the three arithmetic steps and
// the result handshake. Depends on ipe_pkg.
`timescale 1ns / 1ps

module ipe_ctrl
  import ipe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last_byte,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ipe_cmd_t cmd
);

  typedef enum logic [1:0] {COLLECT, SNAP, CALC, RESULT} state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == COLLECT);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd      = '0;
    cmd.take = in_valid && in_ready;
    cmd.snap = (state == SNAP);
    cmd.calc = (state == CALC);
    cmd.load = (state == RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= COLLECT;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        COLLECT: begin
          if (in_valid && last_byte) state <= SNAP;
        end
        SNAP: begin
          state <= CALC;
        end
        CALC: begin
          state <= RESULT;
        end
        RESULT: begin
          if (out_free) state <= COLLECT;
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

  last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> !in_ready ##1 !in_ready)
    else $error("input taken during arithmetic");

  one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.snap, cmd.calc, cmd.load}))
    else $error("overlapping datapath commands");

  load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

  snap_then_calc: assert property (@(posedge clk) disable iff (rst)
    cmd.snap |=> cmd.calc)
    else $error("arithmetic sequence broken");

endmodule

// ----- sv/iso8601_to_epoch_parser_unit.sv -----
// iso8601_to_epoch_parser_unit: top level of the timestamp parser.
// Depends on ipe_pkg, ipe_in_if, ipe_out_if, ipe_ctrl and ipe_dp.
//
// Usage:
//   in_ch carries one text character per transfer (text_byte) with last_byte
//   set on the final character of a timestamp YYYY-MM-DDTHH:MM:SS[.mmm].
//   out_ch carries one result per text: epoch_millis (signed milliseconds
//   since 1970-01-01T00:00:00) and well_formed; a malformed text gives zero
//   with well_formed clear. Only the first 23 characters are examined.
//   Throughput: one character per cycle while collecting; after the last
//   character ready stays low while the day count, century quotients and
//   the final multiply by 86400000 run in three register steps.
//   After the last character's transfer the result passes the snapshot and day
//   count registers and is loaded into the output register, showing valid,
//   once the output register is free.
//   The output register holds a result until taken; the next text is
//   collected meanwhile, and its arithmetic waits in the last step while
//   the receiver stalls.
//   Reset (rst, synchronous) clears the character count, accumulators and
//   the output valid flag.
`timescale 1ns / 1ps

module iso8601_to_epoch_parser_unit
  import ipe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ipe_in_if.sink    in_ch,
  ipe_out_if.source out_ch
);

  ipe_cmd_t cmd;

  ipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .last_byte (in_ch.last_byte),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ipe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .text_byte    (in_ch.text_byte),
    .epoch_millis (out_ch.epoch_millis),
    .well_formed  (out_ch.well_formed)
  );

  malformed_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.well_formed) |-> (out_ch.epoch_millis == 49'sd0))
    else $error("malformed result not zero");

endmodule

// ----- tb/sv/iso_epoch_checker.sv -----
// iso_epoch_checker: watches the text and result channels of the timestamp parser,
// predicts each result from the accepted characters and compares field by field.
// Depends on ipe_pkg, ipe_in_if and ipe_out_if.
`timescale 1ns / 1ps

module iso_epoch_checker
  import ipe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ipe_in_if    in_ch,
  ipe_out_if   out_ch,
  output int   mismatch_count,
  output int   awaited_results
);

  localparam longint DAYS_TO_1970 = 719162;
  localparam longint MS_PER_DAY   = 86400000;
  localparam longint MS_PER_HOUR  = 3600000;
  localparam longint MS_PER_MIN   = 60000;
  localparam longint MS_PER_SEC   = 1000;

  typedef struct packed {
    logic signed [48:0] epoch_millis;
    logic               well_formed;
  } stamp_t;

  stamp_t awaited_stamps[$];
  stamp_t want;
  int     errs;

  logic [4:0]  seen_count;
  logic [13:0] yr_digits;
  logic [6:0]  mon_digits;
  logic [6:0]  dom_digits;
  logic [6:0]  hr_digits;
  logic [6:0]  min_digits;
  logic [6:0]  sec_digits;
  logic [9:0]  ms_digits;
  logic        sep_error;
  logic        dot_seen;

  function automatic void clear_fields();
    seen_count = '0;
    yr_digits  = '0;
    mon_digits = '0;
    dom_digits = '0;
    hr_digits  = '0;
    min_digits = '0;
    sec_digits = '0;
    ms_digits  = '0;
    sep_error  = 1'b0;
    dot_seen   = 1'b0;
  endfunction

  function automatic int days_in_month(input int m);
    case (m)
      2:             return 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint stamp_to_millis(input int yr, input int mon, input int dom,
                                             input int hr, input int mi, input int se,
                                             input int ms);
    longint shifted;
    longint days;
    longint y;
    int     k;
    y       = yr;
    shifted = y + 399;
    days    = 365 * (y - 1) + (shifted / 4 - 100) - (shifted / 100 - 4) + (shifted / 400 - 1);
    for (k = 1; k < mon; k++) days += days_in_month(k);
    if (mon > 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) days++;
    days += dom - 1 - DAYS_TO_1970;
    return days * MS_PER_DAY + hr * MS_PER_HOUR + mi * MS_PER_MIN + se * MS_PER_SEC + ms;
  endfunction

  function automatic void absorb_char(input logic [4:0] p, input logic [7:0] ch);
    logic       is_dig;
    logic [3:0] d;
    is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    d      = is_dig ? 4'(ch - CH_ZERO) : 4'd0;
    case (p)
      POS_DASH_A, POS_DASH_B: begin
        if (ch != CH_DASH) sep_error = 1'b1;
      end
      POS_TEE: begin
        if (ch != CH_TEE) sep_error = 1'b1;
      end
      POS_COLON_A, POS_COLON_B: begin
        if (ch != CH_COLON) sep_error = 1'b1;
      end
      POS_DOT: begin
        dot_seen = (ch == CH_DOT);
      end
      POS_FRAC_A, POS_FRAC_B, POS_FRAC_C: begin
        if (!is_dig) ms_digits = MILLIS_BAD;
        else if (ms_digits != MILLIS_BAD) ms_digits = 10'(ms_digits * 10 + d);
      end
      default: begin
        if (!is_dig) sep_error = 1'b1;
        else if (p <= POS_YEAR_END) yr_digits = 14'(yr_digits * 10 + d);
        else if (p <= POS_MON_END) mon_digits = 7'(mon_digits * 10 + d);
        else if (p <= POS_DAY_END) dom_digits = 7'(dom_digits * 10 + d);
        else if (p <= POS_HOUR_END) hr_digits = 7'(hr_digits * 10 + d);
        else if (p <= POS_MIN_END) min_digits = 7'(min_digits * 10 + d);
        else sec_digits = 7'(sec_digits * 10 + d);
      end
    endcase
  endfunction

  function automatic void consume_char(input logic [7:0] ch, input logic fin);
    logic [4:0] p;
    logic [4:0] cnt;
    logic [9:0] ms_used;
    logic       ok;
    stamp_t     e;
    p = seen_count;
    if (p < FRACTION_LEN) absorb_char(p, ch);
    cnt        = (p >= POS_SATURATE) ? POS_SATURATE : p + 5'd1;
    seen_count = cnt;
    if (fin) begin
      ms_used = (cnt >= FRACTION_LEN && dot_seen) ? ms_digits : 10'd0;
      ok = (cnt >= MIN_TEXT_LEN) && !sep_error
           && mon_digits >= 1 && mon_digits <= 12
           && dom_digits >= 1 && dom_digits <= 31
           && hr_digits <= 23 && min_digits <= 59 && sec_digits <= 59
           && ms_used <= MILLIS_MAX;
      e.well_formed  = ok;
      e.epoch_millis = ok ? 49'(stamp_to_millis(yr_digits, mon_digits, dom_digits, hr_digits,
                                               min_digits, sec_digits, ms_used)) : '0;
      awaited_stamps.push_back(e);
      clear_fields();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_fields();
      awaited_stamps.delete();
      errs = 0;
      mismatch_count  <= 0;
      awaited_results <= 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (awaited_stamps.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %0d / %0b", $time,
                   out_ch.epoch_millis, out_ch.well_formed);
          errs++;
        end else begin
          want = awaited_stamps.pop_front();
          if (out_ch.epoch_millis !== want.epoch_millis) begin
            $display("%0t: epoch_millis mismatch, expected %0d, actual %0d", $time,
                     $signed(want.epoch_millis), out_ch.epoch_millis);
            errs++;
          end
          if (out_ch.well_formed !== want.well_formed) begin
            $display("%0t: well_formed mismatch, expected %0b, actual %0b", $time,
                     want.well_formed, out_ch.well_formed);
            errs++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        consume_char(in_ch.text_byte, in_ch.last_byte);
      end
      mismatch_count  <= errs;
      awaited_results <= awaited_stamps.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: drives timestamp texts into the parser with random gaps and result stalls,
// then reports the verdict from the checker's mismatch and awaited result counts.
// Depends on ipe_pkg, ipe_in_if, ipe_out_if, iso_epoch_checker and the parser top.
`timescale 1ns / 1ps

module tb_top;
  import ipe_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 800;
  localparam int MIN_TEXTS    = 35;
  localparam int CALM_AFTER   = 650;
  localparam int TAIL_CYCLES  = 16;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   awaited_results;
  int   bytes_sent;
  int   texts_sent;
  int   cycles;
  bit   hold_req;
  bit   calm;
  bit   tx_gaps;

  ipe_in_if  text_ch ();
  ipe_out_if result_ch ();

  iso8601_to_epoch_parser_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (text_ch),
    .out_ch (result_ch)
  );

  iso_epoch_checker stamp_check (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (text_ch),
    .out_ch          (result_ch),
    .mismatch_count  (mismatch_count),
    .awaited_results (awaited_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic text_t from_str(input string s);
    text_t t;
    int    i;
    for (i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic void put_digits(ref text_t t, input int unsigned v, input int n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      t.push_back(8'(CH_ZERO + (v / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic int pick_field(input int lo, input int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 99);
    return $urandom_range(lo, hi);
  endfunction

  // mostly well-formed stamps with random content, the rest mutated, cut short or noise
  function automatic text_t random_text();
    text_t t;
    int    kind;
    int    n;
    int    yr;
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      n = $urandom_range(1, 30);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
      return t;
    end
    if ($urandom_range(0, 9) == 0) yr = $urandom_range(0, 1) ? 9999 : 0;
    else yr = $urandom_range(0, 9999);
    put_digits(t, yr, 4);
    t.push_back(CH_DASH);
    put_digits(t, pick_field(1, 12), 2);
    t.push_back(CH_DASH);
    put_digits(t, pick_field(1, 31), 2);
    t.push_back(CH_TEE);
    put_digits(t, pick_field(0, 23), 2);
    t.push_back(CH_COLON);
    put_digits(t, pick_field(0, 59), 2);
    t.push_back(CH_COLON);
    put_digits(t, pick_field(0, 59), 2);
    if ($urandom_range(0, 1)) begin
      t.push_back(CH_DOT);
      put_digits(t, $urandom_range(0, 999), 3);
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) t.push_back(8'($urandom_range(0, 255)));
    end
    if (kind >= 70 && kind < 82) begin
      if ($urandom_range(0, 1)) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
      else t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(CH_DASH, CH_TEE));
    end else if (kind >= 82) begin
      n = $urandom_range(1, t.size() - 1);
      while (t.size() > n) void'(t.pop_back());
    end
    return t;
  endfunction

  task automatic send_text(input text_t t);
    int i;
    for (i = 0; i < t.size(); i++) begin
      text_ch.valid     <= 1'b1;
      text_ch.text_byte <= t[i];
      text_ch.last_byte <= (i == t.size() - 1);
      do @(posedge clk); while (text_ch.ready !== 1'b1);
      bytes_sent++;
      if (tx_gaps && !calm && $urandom_range(0, 5) == 0) begin
        text_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    texts_sent++;
  endtask

  task automatic drain_results();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results != 0) @(posedge clk);
  endtask

  // result side: random stall bursts, stall-free stretches and one-off long hold-offs
  initial begin : result_side
    int  mode_left;
    int  hold_count;
    bit  rx_gaps;
    result_ch.ready <= 1'b0;
    mode_left = 0;
    rx_gaps   = 1'b0;
    repeat (RESET_CYCLES + 1) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        rx_gaps   = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end else if (rx_gaps && !calm && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : text_side
    text_t t;
    int    base_bytes;
    int    base_texts;
    int    k;
    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= 8'h00;
    text_ch.last_byte <= 1'b0;
    hold_req   = 1'b0;
    calm       = 1'b0;
    tx_gaps    = 1'b1;
    bytes_sent = 0;
    texts_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_text(from_str("1970-01-01T00:00:00"));
    send_text(from_str("0000-01-01T00:00:00"));
    send_text(from_str("9999-12-31T23:59:59.999"));
    send_text(from_str("2000-02-29T12:34:56.789"));
    send_text(from_str("1900-03-01T00:00:00.000"));
    send_text(from_str("2023-02-31T08:00:00"));
    send_text(from_str("2024-13-01T00:00:00"));
    send_text(from_str("2024-00-10T00:00:00"));
    send_text(from_str("2024-01-00T00:00:00"));
    send_text(from_str("2024-01-32T00:00:00"));
    send_text(from_str("2024-01-01T24:00:00"));
    send_text(from_str("2024-01-01T00:60:00"));
    send_text(from_str("2024-01-01T00:00:60"));
    send_text(from_str("2024-01-01T00:00:0"));
    send_text(from_str("7"));
    send_text(from_str("2024/01-01T00:00:00"));
    send_text(from_str("2024-01-01 00:00:00"));
    send_text(from_str("2024-01-01T00-00:00"));
    send_text(from_str("20a4-01-01T00:00:00"));
    send_text(from_str("2024-01-01T00:00:00.1x3"));
    send_text(from_str("2024-01-01T00:00:00Z123"));
    send_text(from_str("2024-01-01T00:00:00.12"));
    send_text(from_str("2024-06-15T10:20:30.456+02:00:00:00"));
    t = from_str("1999-12-31T23:59:59.000");
    t[19] = 8'h00;
    t[22] = 8'hff;
    send_text(t);
    t[5] = 8'hff;
    send_text(t);
    drain_results();

    base_bytes = bytes_sent;
    base_texts = texts_sent;
    while (bytes_sent - base_bytes < RANDOM_BYTES || texts_sent - base_texts < MIN_TEXTS) begin
      k = texts_sent - base_texts;
      if (k == 8 || k == 30) hold_req = 1'b1;
      if (k == 25) drain_results();
      if (bytes_sent - base_bytes >= CALM_AFTER) calm = 1'b1;
      tx_gaps = $urandom_range(0, 2) != 0;
      send_text(random_text());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
